>>> rtl/shabh_pkg.sv
// ----------------------------------------------------------------------------
// shabh_pkg
// Shared types, constants and round functions for the SHA-256 byte stream
// hasher.
// ----------------------------------------------------------------------------
package shabh_pkg;

   localparam int WORD_W      = 32;
   localparam int DIGEST_LEN  = 8;
   localparam int ROUNDS      = 64;

   localparam logic [7:0]  PAD_BYTE   = 8'h80;
   // word position in the block where the 64-bit length starts
   localparam logic [3:0]  LEN_HI_POS = 4'd14;
   localparam logic [2:0]  LAST_IDX   = 3'd7;

   // one 32-bit message word on its way from front to back
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              msg_end;   // last word of the last block of a message
   } word_entry_type;

   // initial hash value
   function automatic logic [WORD_W-1:0] init_word(input logic [2:0] idx);
      logic [WORD_W-1:0] w;
      begin
         case (idx)
            3'd0: w = 32'h6a09e667;
            3'd1: w = 32'hbb67ae85;
            3'd2: w = 32'h3c6ef372;
            3'd3: w = 32'ha54ff53a;
            3'd4: w = 32'h510e527f;
            3'd5: w = 32'h9b05688c;
            3'd6: w = 32'h1f83d9ab;
            3'd7: w = 32'h5be0cd19;
            default: w = 32'h6a09e667;
         endcase
         return w;
      end
   endfunction

   // round constants
   function automatic logic [WORD_W-1:0] round_k(input logic [5:0] t);
      logic [WORD_W-1:0] k;
      begin
         case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h428a2f98;
         endcase
         return k;
      end
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

>>> rtl/shabh_if.sv
// ----------------------------------------------------------------------------
// shabh_if
// Valid/ready channels of the hasher: message bytes in, digest words out.
// ----------------------------------------------------------------------------
interface shabh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface shabh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> rtl/shabh_front.sv
// ----------------------------------------------------------------------------
// shabh_front
// Packs message bytes into big-endian words, counts the bit length and
// appends the padding and length words at the end of a message.
// ----------------------------------------------------------------------------
module shabh_front
   import shabh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   shabh_req_if.sink      req_chan,
   output logic           push_valid,
   output word_entry_type push_data,
   input  logic           push_ready
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_PAD  = 4'b0010,
      F_ZERO = 4'b0100,
      F_LEN  = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [5:0]      fill_ff, fill_in;      // bytes held in the current block
   logic [31:0]     acc_ff, acc_in;        // partial word
   logic [63:0]     bitlen_ff, bitlen_in;

   logic            fire;
   logic [3:0]      pos;
   logic [4:0]      sh;
   logic [31:0]     ins_word;
   logic [31:0]     pad_word;

   assign pos = fill_ff[5:2];
   assign sh  = {fill_ff[1:0], 3'b000};

   // new byte dropped into its lane; pad byte after the kept lanes
   assign ins_word = (acc_ff & ~(32'hff000000 >> sh)) | ({req_chan.data_byte, 24'h0} >> sh);
   assign pad_word = (acc_ff & ~(32'hffffffff >> sh)) | ({PAD_BYTE, 24'h0} >> sh);

   assign req_chan.ready = (state_ff == F_IDLE) && push_ready;
   assign fire           = req_chan.valid && req_chan.ready;

   // next state and word push
   always_comb begin
      state_in          = state_ff;
      fill_in           = fill_ff;
      acc_in            = acc_ff;
      bitlen_in         = bitlen_ff;
      push_valid        = 1'b0;
      push_data.word    = ins_word;
      push_data.msg_end = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (fire) begin
               if (req_chan.byte_valid) begin
                  acc_in    = ins_word;
                  fill_in   = 6'(fill_ff + 6'd1);
                  bitlen_in = 64'(bitlen_ff + 64'd8);
                  push_valid = (fill_ff[1:0] == 2'd3);
               end
               if (req_chan.end_of_message) begin
                  state_in = F_PAD;
               end
            end
         end
         F_PAD: begin
            push_valid     = 1'b1;
            push_data.word = pad_word;
            if (push_ready) begin
               fill_in  = {4'(pos + 4'd1), 2'b00};
               state_in = F_ZERO;
            end
         end
         F_ZERO: begin
            push_valid     = 1'b1;
            push_data.word = (pos == LEN_HI_POS) ? bitlen_ff[63:32] : 32'h0;
            if (push_ready) begin
               fill_in = {4'(pos + 4'd1), 2'b00};
               if (pos == LEN_HI_POS) begin
                  state_in = F_LEN;
               end
            end
         end
         F_LEN: begin
            push_valid        = 1'b1;
            push_data.word    = bitlen_ff[31:0];
            push_data.msg_end = 1'b1;
            if (push_ready) begin
               fill_in   = 6'd0;
               bitlen_in = 64'd0;
               state_in  = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         fill_ff   <= 6'd0;
         bitlen_ff <= 64'd0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bitlen_ff <= bitlen_in;
      end
   end

   // partial word
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

>>> rtl/shabh_queue.sv
// ----------------------------------------------------------------------------
// shabh_queue
// Small register queue of message words between front and back.
// ----------------------------------------------------------------------------
module shabh_queue
   import shabh_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  word_entry_type push_data,
   output logic           push_ready,
   output logic           pop_valid,
   output word_entry_type pop_data,
   input  logic           pop_ready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   word_entry_type slot_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/shabh_back.sv
// ----------------------------------------------------------------------------
// shabh_back
// SHA-256 compression, one round per cycle unless waiting on a queue word,
// with a rolling 16-word schedule, then the chaining add and digest readout.
// ----------------------------------------------------------------------------
module shabh_back
   import shabh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   input  word_entry_type pop_data,
   output logic           pop_ready,
   shabh_rsp_if.source    rsp_chan
);

   typedef enum logic [3:0] {
      B_LOAD  = 4'b0001,
      B_ROUND = 4'b0010,
      B_ADD   = 4'b0100,
      B_OUT   = 4'b1000
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [5:0]        round_ff, round_in;
   logic [2:0]        out_idx_ff, out_idx_in;
   logic              msg_end_ff, msg_end_in;
   logic [WORD_W-1:0] chain_ff [DIGEST_LEN];
   logic [WORD_W-1:0] chain_in [DIGEST_LEN];
   logic [WORD_W-1:0] vars_ff  [DIGEST_LEN];
   logic [WORD_W-1:0] vars_in  [DIGEST_LEN];
   logic [WORD_W-1:0] win_ff   [16];
   logic [WORD_W-1:0] win_in   [16];

   logic              load_phase;
   logic              step;
   logic              rsp_fire;
   logic [WORD_W-1:0] w_sched, w_cur, t1, t2;

   assign load_phase = (round_ff[5:4] == 2'b00);
   assign pop_ready  = (state_ff == B_ROUND) && load_phase;
   assign step       = (state_ff == B_ROUND) && (!load_phase || pop_valid);

   assign rsp_chan.valid       = (state_ff == B_OUT);
   assign rsp_chan.digest_word = chain_ff[0];
   assign rsp_chan.word_index  = out_idx_ff;
   assign rsp_chan.last_word   = (out_idx_ff == LAST_IDX);
   assign rsp_fire             = rsp_chan.valid && rsp_chan.ready;

   // message schedule: window holds w[t-16] .. w[t-1], oldest first
   assign w_sched = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9] + small_sigma1(win_ff[14]);
   assign w_cur   = load_phase ? pop_data.word : w_sched;

   // round arithmetic
   assign t1 = vars_ff[7] + big_sigma1(vars_ff[4])
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
             + round_k(round_ff) + w_cur;
   assign t2 = big_sigma0(vars_ff[0])
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]));

   // sequencer
   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;
      msg_end_in = msg_end_ff;
      chain_in   = chain_ff;
      vars_in    = vars_ff;
      win_in     = win_ff;
      case (state_ff)
         B_LOAD: begin
            vars_in  = chain_ff;
            round_in = 6'd0;
            state_in = B_ROUND;
         end
         B_ROUND: begin
            if (step) begin
               for (int i = 0; i < 15; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[15] = w_cur;
               vars_in[0] = t1 + t2;
               vars_in[1] = vars_ff[0];
               vars_in[2] = vars_ff[1];
               vars_in[3] = vars_ff[2];
               vars_in[4] = vars_ff[3] + t1;
               vars_in[5] = vars_ff[4];
               vars_in[6] = vars_ff[5];
               vars_in[7] = vars_ff[6];
               if (round_ff == 6'(ROUNDS - 1)) begin
                  state_in = B_ADD;
               end
               if (round_ff == 6'd15) begin
                  msg_end_in = pop_data.msg_end;
               end
               round_in = 6'(round_ff + 6'd1);
            end
         end
         B_ADD: begin
            for (int i = 0; i < DIGEST_LEN; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
            out_idx_in = 3'd0;
            state_in   = msg_end_ff ? B_OUT : B_LOAD;
         end
         B_OUT: begin
            if (rsp_fire) begin
               // shift the digest toward word 0
               for (int i = 0; i < DIGEST_LEN - 1; i++) begin
                  chain_in[i] = chain_ff[i+1];
               end
               chain_in[DIGEST_LEN-1] = chain_ff[0];
               out_idx_in = 3'(out_idx_ff + 3'd1);
               if (out_idx_ff == LAST_IDX) begin
                  for (int i = 0; i < DIGEST_LEN; i++) begin
                     chain_in[i] = init_word(3'(i));
                  end
                  state_in = B_LOAD;
               end
            end
         end
         default: begin
            state_in = B_LOAD;
         end
      endcase
   end

   // control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_LOAD;
         round_ff   <= 6'd0;
         out_idx_ff <= 3'd0;
         msg_end_ff <= 1'b0;
         for (int i = 0; i < DIGEST_LEN; i++) begin
            chain_ff[i] <= init_word(3'(i));
         end
      end else begin
         state_ff   <= state_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
         msg_end_ff <= msg_end_in;
         chain_ff   <= chain_in;
      end
   end

   // working variables and schedule window
   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      win_ff  <= win_in;
   end

endmodule

>>> rtl/sha256_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream: message bytes in, eight digest words out.
// ----------------------------------------------------------------------------
//
//   channel   dir  payload                                  transaction
//   req_chan  in   data_byte, byte_valid, end_of_message    one byte / end
//   rsp_chan  out  digest_word, word_index, last_word       one digest word
//
// A byte transaction is taken while the front is idle and the queue has room.
// Each 16-word block passes the compression unit as load, 64 rounds and
// chaining add; the round unit sets the sustained byte rate.
// At end of message the front appends padding and length words; after final
// compression the eight digest words leave one per cycle while rsp is ready.
// Reset is synchronous; no clearing pass. Either side may stall at any time.
//
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top
   import shabh_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   shabh_req_if.sink   req_chan,
   shabh_rsp_if.source rsp_chan
);

   logic           push_valid, push_ready;
   word_entry_type push_data;
   logic           pop_valid, pop_ready;
   word_entry_type pop_data;

   // byte packing and padding
   shabh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // word queue
   shabh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // compression and digest readout
   shabh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

   // no byte is taken while the queue refuses the front's word
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |=> !$past(req_chan.valid && req_chan.ready))
      else $error("front pushed a word into a full queue");

   // last word flag marks word seven only
   a_last_is_seven: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_word |-> rsp_chan.word_index == LAST_IDX)
      else $error("last_word on a word other than the eighth");

   // after the digest is taken the back reloads before anything else leaves
   a_gap_after_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_word |=> !rsp_chan.valid)
      else $error("digest output continued past the eighth word");

   // the digest starts at word zero
   a_digest_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> rsp_chan.word_index == 3'd0)
      else $error("digest readout did not start at word zero");

endmodule
